[hdl/hash_group_id_assigner_assert.svh]
// ----------------------------------------------------------------------------
// hash_group_id_assigner_assert.svh
// Assertion macros shared by the grouping block.
// ----------------------------------------------------------------------------
`ifndef HASH_GROUP_ID_ASSIGNER_ASSERT_SVH
`define HASH_GROUP_ID_ASSIGNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HGA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m assertion failed");

`endif

[hdl/hga_pkg.sv]
// ----------------------------------------------------------------------------
// hga_pkg
// Types and constants of the hash group id assigner.
// ----------------------------------------------------------------------------
package hga_pkg;

    localparam int KEY_W   = 64;
    localparam int PREV_W  = 17;
    localparam int GID_W   = 17;
    localparam int BITS_W  = 5;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0]        HASH_MULT       = 32'd3141592653;
    localparam logic [BITS_W-1:0]  MIN_TABLE_BITS  = 5'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_KIND     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_PREV = 2'd2;

    // key kinds
    localparam logic [1:0] KIND_INT32  = 2'd0;
    localparam logic [1:0] KIND_PAIR64 = 2'd1;
    localparam logic [1:0] KIND_HANDLE = 2'd2;

    // item opcodes
    localparam logic OP_GROUP = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // classified work item, front to back
    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [PREV_W-1:0] prev;
        logic              cmp_full;
        logic              use_prev;
        logic [BITS_W-1:0] bits;
    } t_item;

    // one table slot as kept in memory
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [PREV_W-1:0] prev;
        logic [GID_W-1:0]  group;
    } t_slot_entry;

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_PROBE,
        ST_CLR_ACK
    } t_back_state;

    // back-end status seen by the front and the top level
    typedef struct packed {
        logic wiping;
        logic init_wipe;
    } t_back_stat;

endpackage

[hdl/hga_ram.sv]
// ----------------------------------------------------------------------------
// hga_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hga_ram #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 8
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [DEPTH_LOG2-1:0] i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic                  i_re,
    input  logic [DEPTH_LOG2-1:0] i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [2**DEPTH_LOG2];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/hga_fifo.sv]
// ----------------------------------------------------------------------------
// hga_fifo
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module hga_fifo #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_ready,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_valid
);

    localparam int DEPTH = 2**DEPTH_LOG2;

    logic [WIDTH-1:0]      r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wptr;
    logic [DEPTH_LOG2-1:0] r_rptr;
    logic [DEPTH_LOG2:0]   r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_ready = (r_count != (DEPTH_LOG2+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + DEPTH_LOG2'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + DEPTH_LOG2'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (DEPTH_LOG2+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (DEPTH_LOG2+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[hdl/hga_front.sv]
// ----------------------------------------------------------------------------
// hga_front
// Accepts items, folds the key word and hashes it to a home slot.
// ----------------------------------------------------------------------------
module hga_front
    import hga_pkg::*;
#(
    parameter int MAX_TABLE_BITS = 17
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [BITS_W-1:0]         i_table_bits,
    input  logic [1:0]                i_key_kind,
    input  logic                      i_combine_prev,
    input  t_back_stat                i_stat,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_op,
    input  logic [KEY_W-1:0]          i_key,
    input  logic [PREV_W-1:0]         i_prev_group,
    output logic                      o_q_push,
    output t_item                     o_q_item,
    output logic [MAX_TABLE_BITS-1:0] o_q_slot,
    input  logic                      i_q_ready
);

    localparam int TW = MAX_TABLE_BITS;

    logic        r_a_valid;
    t_item       r_a_item;
    logic [31:0] r_a_word;
    logic        r_b_valid;
    t_item       r_b_item;
    logic [31:0] r_b_hk;
    logic [31:0] r_b_hp;

    logic              b_adv;
    logic              accept;
    t_item             in_item;
    logic [31:0]       in_word;
    logic [BITS_W-1:0] eff_bits;
    logic [31:0]       hash;
    logic [31:0]       hash_top;
    logic [5:0]        shamt;

    assign b_adv      = !r_b_valid || i_q_ready;
    assign o_in_stall = i_stat.init_wipe || (r_a_valid && !b_adv);
    assign accept     = i_in_valid && !o_in_stall;

    // table size clamp
    always_comb begin
        if (i_table_bits < MIN_TABLE_BITS) begin
            eff_bits = MIN_TABLE_BITS;
        end else if (i_table_bits > BITS_W'(MAX_TABLE_BITS)) begin
            eff_bits = BITS_W'(MAX_TABLE_BITS);
        end else begin
            eff_bits = i_table_bits;
        end
    end

    // key classification; the unused kind code behaves as int32
    always_comb begin
        in_item.op       = i_op;
        in_item.key      = i_key;
        in_item.prev     = i_prev_group;
        in_item.use_prev = i_combine_prev;
        in_item.bits     = eff_bits;
        case (i_key_kind)
            KIND_PAIR64: begin
                in_word          = i_key[31:0] + i_key[63:32];
                in_item.cmp_full = 1'b1;
            end
            KIND_HANDLE: begin
                in_word          = i_key[31:0];
                in_item.cmp_full = 1'b1;
            end
            default: begin
                in_word          = i_key[31:0];
                in_item.cmp_full = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_a_valid <= i_in_valid;
            end
            if (b_adv) begin
                r_b_valid <= r_a_valid && !o_in_stall;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_item <= in_item;
            r_a_word <= in_word;
        end
        if (b_adv && r_a_valid) begin
            r_b_item <= r_a_item;
            r_b_hk   <= r_a_word * HASH_MULT;
            r_b_hp   <= 32'(r_a_item.prev) * HASH_MULT;
        end
    end

    // home slot: top eff_bits bits of the 32-bit hash
    assign hash     = r_b_item.use_prev ? (r_b_hk ^ r_b_hp) : r_b_hk;
    assign shamt    = 6'd32 - {1'b0, r_b_item.bits};
    assign hash_top = hash >> shamt;

    assign o_q_push = r_b_valid;
    assign o_q_item = r_b_item;
    assign o_q_slot = hash_top[TW-1:0];

endmodule

[hdl/hga_back.sv]
// ----------------------------------------------------------------------------
// hga_back
// Linear-probe engine: slot memory, group counter and result register.
// ----------------------------------------------------------------------------
module hga_back
    import hga_pkg::*;
#(
    parameter int MAX_TABLE_BITS = 17,
    parameter int MAX_ITEMS      = 65536
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  t_item                     i_q_item,
    input  logic [MAX_TABLE_BITS-1:0] i_q_slot,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [GID_W-1:0]          o_group_id,
    output logic                      o_first_seen,
    output logic [GID_W-1:0]          o_group_count,
    output logic                      o_table_full,
    output t_back_stat                o_stat
);

    localparam int TW = MAX_TABLE_BITS;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_back_state r_state;
    t_back_state n_state;

    t_item            r_item;
    logic [TW-1:0]    r_slot;
    logic [TW-1:0]    r_probes;
    logic [TW-1:0]    r_sweep;
    logic             r_pend_clr;
    logic [CW-1:0]    r_count;
    logic             r_out_valid;
    logic [GID_W-1:0] r_out_gid;
    logic             r_out_first;
    logic [GID_W-1:0] r_out_cnt;
    logic             r_out_full;

    // memory port
    logic          ram_we;
    logic [TW-1:0] ram_waddr;
    t_slot_entry   ram_wdata;
    logic          ram_re;
    logic [TW-1:0] ram_raddr;
    t_slot_entry   rd;

    // probe decision
    logic          out_free;
    logic [TW-1:0] probe_mask;
    logic [TW-1:0] slot_next;
    logic          key_eq;
    logic          prev_eq;
    logic          hit;
    logic          vacant;
    logic          at_limit;
    logic          last;
    logic          resolve;
    logic [31:0]   cnt_wide;
    logic [31:0]   cnt_inc_wide;

    // actions
    logic             take;
    logic             advance;
    logic             cnt_clr;
    logic             cnt_inc;
    logic             out_load;
    logic [GID_W-1:0] out_gid;
    logic             out_first;
    logic             out_full;

    hga_ram #(
        .WIDTH      ($bits(t_slot_entry)),
        .DEPTH_LOG2 (TW)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign out_free     = !r_out_valid || !i_out_stall;
    assign probe_mask   = ~({TW{1'b1}} << r_item.bits);
    assign slot_next    = (r_slot + TW'(1)) & probe_mask;
    assign key_eq       = r_item.cmp_full ? (rd.key == r_item.key)
                                          : (rd.key[31:0] == r_item.key[31:0]);
    assign prev_eq      = !r_item.use_prev || (rd.prev == r_item.prev);
    assign hit          = rd.valid && key_eq && prev_eq;
    assign vacant       = !rd.valid;
    assign at_limit     = (r_count == CW'(MAX_ITEMS));
    assign last         = (r_probes == probe_mask);
    assign resolve      = vacant || hit || last;
    assign cnt_wide     = 32'(r_count);
    assign cnt_inc_wide = cnt_wide + 32'd1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_WIPE: begin
                if (r_sweep == {TW{1'b1}}) begin
                    n_state = r_pend_clr ? ST_CLR_ACK : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_item.op == OP_CLEAR) ? ST_WIPE : ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (resolve && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLR_ACK: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        take      = 1'b0;
        advance   = 1'b0;
        cnt_clr   = 1'b0;
        cnt_inc   = 1'b0;
        out_load  = 1'b0;
        out_gid   = '0;
        out_first = 1'b0;
        out_full  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = i_q_slot;
        unique case (r_state)
            ST_WIPE: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    take = 1'b1;
                    if (i_q_item.op == OP_CLEAR) begin
                        cnt_clr = 1'b1;
                    end else begin
                        ram_re = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (!resolve) begin
                    advance   = 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = slot_next;
                end else if (out_free) begin
                    out_load = 1'b1;
                    if (hit) begin
                        out_gid = rd.group;
                    end else if (vacant && !at_limit) begin
                        cnt_inc         = 1'b1;
                        out_gid         = cnt_inc_wide[GID_W-1:0];
                        out_first       = 1'b1;
                        ram_we          = 1'b1;
                        ram_wdata.valid = 1'b1;
                        ram_wdata.key   = r_item.key;
                        ram_wdata.prev  = r_item.prev;
                        ram_wdata.group = cnt_inc_wide[GID_W-1:0];
                    end else begin
                        // no free slot, or group limit reached
                        out_full = 1'b1;
                    end
                end
            end
            ST_CLR_ACK: begin
                out_load = out_free;
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WIPE;
            r_sweep     <= '0;
            r_pend_clr  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_WIPE) begin
                r_sweep <= r_sweep + TW'(1);
            end
            if (cnt_clr) begin
                r_pend_clr <= 1'b1;
            end else if (r_state == ST_CLR_ACK && out_free) begin
                r_pend_clr <= 1'b0;
            end
            if (cnt_clr) begin
                r_count <= '0;
            end else if (cnt_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item   <= i_q_item;
            r_slot   <= i_q_slot;
            r_probes <= '0;
        end else if (advance) begin
            r_slot   <= slot_next;
            r_probes <= r_probes + TW'(1);
        end
        if (out_load) begin
            r_out_gid   <= out_gid;
            r_out_first <= out_first;
            r_out_full  <= out_full;
            if (cnt_inc) begin
                r_out_cnt <= cnt_inc_wide[GID_W-1:0];
            end else begin
                r_out_cnt <= cnt_wide[GID_W-1:0];
            end
        end
    end

    assign o_q_pop          = take;
    assign o_out_valid      = r_out_valid;
    assign o_group_id       = r_out_gid;
    assign o_first_seen     = r_out_first;
    assign o_group_count    = r_out_cnt;
    assign o_table_full     = r_out_full;
    assign o_stat.wiping    = (r_state == ST_WIPE);
    assign o_stat.init_wipe = (r_state == ST_WIPE) && !r_pend_clr;

endmodule

[hdl/hash_group_id_assigner.sv]
// ----------------------------------------------------------------------------
// hash_group_id_assigner
// Dense group numbering of keys through a linear-probing hash table.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | beat contents
//  ---------+----------------------------+------------------------------------
//  in       | i_in_valid / o_in_stall    | i_op, i_key, i_prev_group
//  out      | o_out_valid / i_out_stall  | o_group_id, o_first_seen,
//           |                            | o_group_count, o_table_full
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Per item: dequeue and home-slot read, then compare, plus one more read
//    and compare per extra probe; the single slot-memory read port paced
//    by the probe loop sets this. The front end adds its A and B registers.
//  Reset: a sweep over 2**MAX_TABLE_BITS slots (131072 by default) zeroes the
//    slot valid bits; no input beat is taken meanwhile, config writes are.
//  Clear op: the same full sweep inside the back end, then the result beat.
//  Stalls: a 2-entry queue lets the front keep hashing while the back end
//    probes; the output register holds a result while the next item probes.
//
module hash_group_id_assigner
    import hga_pkg::*;
#(
    parameter int MAX_TABLE_BITS = 17,
    parameter int MAX_ITEMS      = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [PREV_W-1:0]    i_prev_group,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [GID_W-1:0]     o_group_id,
    output logic                 o_first_seen,
    output logic [GID_W-1:0]     o_group_count,
    output logic                 o_table_full,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    `include "hash_group_id_assigner_assert.svh"

    localparam int TW = MAX_TABLE_BITS;

    // configuration registers
    logic [BITS_W-1:0] r_table_bits;
    logic [1:0]        r_key_kind;
    logic              r_combine_prev;

    // front to queue
    logic          f_push;
    t_item         f_item;
    logic [TW-1:0] f_slot;
    logic          q_ready;

    // queue to back
    logic          q_valid;
    logic          q_pop;
    t_item         q_item;
    logic [TW-1:0] q_slot;

    t_back_stat back_stat;

    // config writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_bits   <= MIN_TABLE_BITS;
            r_key_kind     <= KIND_INT32;
            r_combine_prev <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TABLE_BITS:   r_table_bits   <= i_cfg_data;
                CFG_KEY_KIND:     r_key_kind     <= i_cfg_data[1:0];
                CFG_COMBINE_PREV: r_combine_prev <= i_cfg_data[0];
                default:          r_combine_prev <= r_combine_prev;
            endcase
        end
    end

    hga_front #(
        .MAX_TABLE_BITS (MAX_TABLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_table_bits   (r_table_bits),
        .i_key_kind     (r_key_kind),
        .i_combine_prev (r_combine_prev),
        .i_stat         (back_stat),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_prev_group   (i_prev_group),
        .o_q_push       (f_push),
        .o_q_item       (f_item),
        .o_q_slot       (f_slot),
        .i_q_ready      (q_ready)
    );

    hga_fifo #(
        .WIDTH      ($bits(t_item) + TW),
        .DEPTH_LOG2 (1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata ({f_slot, f_item}),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_rdata ({q_slot, q_item}),
        .o_valid (q_valid)
    );

    hga_back #(
        .MAX_TABLE_BITS (MAX_TABLE_BITS),
        .MAX_ITEMS      (MAX_ITEMS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .i_q_slot      (q_slot),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_group_id    (o_group_id),
        .o_first_seen  (o_first_seen),
        .o_group_count (o_group_count),
        .o_table_full  (o_table_full),
        .o_stat        (back_stat)
    );

    // a new group carries the running count as its id
    `HGA_ASSERT_IMPL(a_first_is_count, i_clk, i_rst_n, o_out_valid && o_first_seen, (o_group_id == o_group_count) && !o_table_full)
    // an ungrouped item reports no id
    `HGA_ASSERT_IMPL(a_full_no_id, i_clk, i_rst_n, o_out_valid && o_table_full, (o_group_id == '0) && !o_first_seen)
    // nothing leaves the queue while the slot memory is being wiped
    `HGA_ASSERT_IMPL(a_no_pop_in_wipe, i_clk, i_rst_n, back_stat.wiping, !q_pop)
    // a dequeued clear op starts the wipe
    `HGA_ASSERT_NEXT(a_clear_wipes, i_clk, i_rst_n, q_pop && (q_item.op == OP_CLEAR), back_stat.wiping)

endmodule
